// ===== rtl/core/crcfps_pkg.sv =====
// Shared types, constants and the CRC step function for the framed packet sender.
// Used by crcfps_cfg_regs, crcfps_seq and the top level; depends on nothing.
`default_nettype none

package crcfps_pkg;

  localparam int PACKET_BYTES_DEF = 32;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_MSB     = 16'h8000;
  localparam logic [7:0]  FRAME_START = 8'h3A;

  localparam logic [15:0] BASE_ADDRESS_RST  = 16'h0000;
  localparam logic [3:0]  ATTEMPT_LIMIT_RST = 4'd5;
  localparam logic [7:0]  GOOD_ACK_RST      = 8'hF2;

  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_BASE_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd1;
  localparam logic [1:0] REG_GOOD_ACK_CODE = 2'd2;

  localparam logic       KIND_WIRE   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_DELIVERED = 2'd0;
  localparam logic [1:0] STATUS_FAILED    = 2'd1;
  localparam logic [1:0] STATUS_SKIPPED   = 2'd2;

  typedef struct packed {
    logic [15:0] base_address;
    logic [3:0]  attempt_limit;
    logic [7:0]  good_ack_code;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcfps_cfg_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on crcfps_pkg for the register map, reset values and cfg_t.
`default_nettype none

module crcfps_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crcfps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  output crcfps_pkg::cfg_t                         cfg
);

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address  <= crcfps_pkg::BASE_ADDRESS_RST;
      cfg.attempt_limit <= crcfps_pkg::ATTEMPT_LIMIT_RST;
      cfg.good_ack_code <= crcfps_pkg::GOOD_ACK_RST;
    end else if (wr) begin
      case (reg_sel)
        crcfps_pkg::REG_BASE_ADDRESS:  cfg.base_address  <= pwdata[15:0];
        crcfps_pkg::REG_ATTEMPT_LIMIT: cfg.attempt_limit <= pwdata[3:0];
        crcfps_pkg::REG_GOOD_ACK_CODE: cfg.good_ack_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      crcfps_pkg::REG_BASE_ADDRESS:  prdata = {16'h0000, cfg.base_address};
      crcfps_pkg::REG_ATTEMPT_LIMIT: prdata = {28'h0000000, cfg.attempt_limit};
      crcfps_pkg::REG_GOOD_ACK_CODE: prdata = {24'h000000, cfg.good_ack_code};
      default:                       prdata = 32'h00000000;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcfps_store.sv =====
// Packet byte store: one write port and one read port with registered read data.
// Stand-alone; depends on nothing.
`default_nettype none

module crcfps_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcfps_seq.sv =====
// Load, framing and retry sequencer with the result register.
// Depends on crcfps_pkg; drives the packet store and reads back its data.
`default_nettype none

module crcfps_seq #(
  parameter int PACKET_BYTES = crcfps_pkg::PACKET_BYTES_DEF,
  parameter int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire crcfps_pkg::cfg_t cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire logic [7:0]       data_byte,
  input  wire logic [10:0]      packet_index,
  input  wire logic             last_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  item_kind,
  output logic [7:0]            wire_byte,
  output logic [1:0]            status_code,
  output logic [7:0]            ack_seen,
  output logic                  run_last,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [7:0]            wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  wire logic [7:0]       rd_data
);

  localparam int PW = $clog2(PACKET_BYTES + 5);
  localparam logic [PW-1:0] POS_DATA0  = PW'(3);
  localparam logic [PW-1:0] POS_CRC_HI = PW'(PACKET_BYTES + 3);
  localparam logic [PW-1:0] POS_CRC_LO = PW'(PACKET_BYTES + 4);
  localparam logic [AW-1:0] LOAD_LAST  = AW'(PACKET_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t        state;
  logic [PW-1:0] pos;
  logic [AW-1:0] load_count;
  logic          nonzero_seen;
  logic [15:0]   frame_address;
  logic [15:0]   frame_crc;
  logic [3:0]    attempts_left;
  logic          in_flight;

  logic          slot_free;
  logic          acc;
  logic          nz;
  logic          good;
  logic [15:0]   addr_calc;
  logic [PW-1:0] data_off;
  logic [7:0]    emit_byte;
  logic          emit_go;
  logic          out_load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign nz        = nonzero_seen || (data_byte != 8'h00);
  assign good      = data_byte == cfg.good_ack_code;
  assign addr_calc = cfg.base_address + 16'(32'(packet_index) * PACKET_BYTES);
  assign data_off  = pos - POS_DATA0;
  assign emit_go   = (state == S_EMIT) && slot_free;
  assign out_load  = (acc && action && in_flight && (good || attempts_left == 4'd0)) ||
                     (wr_en && last_byte && !nz) || emit_go;

  assign wr_en   = acc && !action && !in_flight;
  assign wr_addr = load_count;
  assign wr_data = data_byte;
  assign rd_en   = state == S_FETCH;
  assign rd_addr = data_off[AW-1:0];

  always_comb begin
    if (pos == PW'(0)) begin
      emit_byte = crcfps_pkg::FRAME_START;
    end else if (pos == PW'(1)) begin
      emit_byte = frame_address[15:8];
    end else if (pos == PW'(2)) begin
      emit_byte = frame_address[7:0];
    end else if (pos < POS_CRC_HI) begin
      emit_byte = rd_data;
    end else if (pos == POS_CRC_HI) begin
      emit_byte = frame_crc[15:8];
    end else begin
      emit_byte = frame_crc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      load_count    <= '0;
      nonzero_seen  <= 1'b0;
      frame_address <= 16'h0000;
      frame_crc     <= crcfps_pkg::CRC_INIT;
      attempts_left <= 4'd0;
      in_flight     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      if (acc && action && in_flight) begin
        if (good) begin
          in_flight   <= 1'b0;
          item_kind   <= crcfps_pkg::KIND_STATUS;
          wire_byte   <= 8'h00;
          status_code <= crcfps_pkg::STATUS_DELIVERED;
          ack_seen    <= data_byte;
          run_last    <= 1'b1;
        end else if (attempts_left != 4'd0) begin
          attempts_left <= attempts_left - 4'd1;
          state         <= S_FETCH;
          pos           <= '0;
          frame_crc     <= crcfps_pkg::CRC_INIT;
        end else begin
          in_flight   <= 1'b0;
          item_kind   <= crcfps_pkg::KIND_STATUS;
          wire_byte   <= 8'h00;
          status_code <= crcfps_pkg::STATUS_FAILED;
          ack_seen    <= data_byte;
          run_last    <= 1'b1;
        end
      end
      if (wr_en) begin
        if (!last_byte) begin
          load_count   <= (load_count == LOAD_LAST) ? '0 : load_count + AW'(1);
          nonzero_seen <= nz;
        end else begin
          load_count    <= '0;
          frame_address <= addr_calc;
          if (!nz) begin
            item_kind   <= crcfps_pkg::KIND_STATUS;
            wire_byte   <= 8'h00;
            status_code <= crcfps_pkg::STATUS_SKIPPED;
            ack_seen    <= 8'h00;
            run_last    <= 1'b1;
          end else begin
            nonzero_seen  <= 1'b0;
            attempts_left <= (cfg.attempt_limit == 4'd0) ? 4'd0 : cfg.attempt_limit - 4'd1;
            in_flight     <= 1'b1;
            state         <= S_FETCH;
            pos           <= '0;
            frame_crc     <= crcfps_pkg::CRC_INIT;
          end
        end
      end
      if (state == S_FETCH) begin
        state <= S_EMIT;
      end
      if (emit_go) begin
        item_kind   <= crcfps_pkg::KIND_WIRE;
        wire_byte   <= emit_byte;
        status_code <= crcfps_pkg::STATUS_DELIVERED;
        ack_seen    <= 8'h00;
        run_last    <= pos == POS_CRC_LO;
        if (pos != PW'(0) && pos < POS_CRC_HI) begin
          frame_crc <= crcfps_pkg::crc_byte(frame_crc, emit_byte);
        end
        if (pos == POS_CRC_LO) begin
          state <= S_IDLE;
        end else begin
          state <= S_FETCH;
          pos   <= pos + PW'(1);
        end
      end
    end
  end

  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |=> state == S_EMIT)
    else $error("fetch not followed by emit");

  a_flight_ends_with_status: assert property (@(posedge clk) disable iff (rst)
    $fell(in_flight) |-> out_valid && item_kind == crcfps_pkg::KIND_STATUS && run_last)
    else $error("packet left flight without a status");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> pos <= POS_CRC_LO)
    else $error("frame position out of range");

  a_frame_means_flight: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_flight)
    else $error("frame emitted with no packet in flight");

endmodule

`default_nettype wire

// ===== rtl/core/crc_framed_packet_sender_retry_top.sv =====
// Top level of the stop-and-wait framed packet sender with CRC-16 and retry.
// Depends on crcfps_pkg, crcfps_cfg_regs, crcfps_store and crcfps_seq.
//
// Input beats carry either a packet data byte (action 0) or a received ack
// byte (action 1, 0 on a timeout). Data bytes are written to the packet store
// at one per cycle while in_ready is high and cause no output until the beat
// marked last_byte. That beat either yields one skipped status beat or starts a
// frame of PACKET_BYTES + 5 wire beats: start mark, address, data and CRC.
// An ack beat yields a status beat, a resent frame, or nothing when no packet
// is in flight. The final beat of each run has run_last set.
// Each wire beat passes through S_FETCH, a store read, and then S_EMIT, which
// loads the output register; S_EMIT waits while out_valid is high and
// out_ready is low. The CRC is computed one byte per beat as the frame goes out.
// Input beats are taken only while no frame is being emitted; a status beat
// appears in the cycle after its input beat.
// Results wait in the output register while out_ready is low and the
// sequencer holds. Reset is synchronous; it clears the control state and
// loads the register reset values, and the block is ready the next cycle.
`default_nettype none

module crc_framed_packet_sender_retry_top #(
  parameter int PACKET_BYTES = crcfps_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [crcfps_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               action,
  input  wire logic [7:0]                         data_byte,
  input  wire logic [10:0]                        packet_index,
  input  wire logic                               last_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    item_kind,
  output logic [7:0]                              wire_byte,
  output logic [1:0]                              status_code,
  output logic [7:0]                              ack_seen,
  output logic                                    run_last
);

  localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  crcfps_pkg::cfg_t cfg;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  crcfps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crcfps_store #(
    .DEPTH (PACKET_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crcfps_seq #(
    .PACKET_BYTES (PACKET_BYTES),
    .AW           (AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .data_byte    (data_byte),
    .packet_index (packet_index),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .wire_byte    (wire_byte),
    .status_code  (status_code),
    .ack_seen     (ack_seen),
    .run_last     (run_last),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

endmodule

`default_nettype wire
